// ===== rtl/tws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

    // Configuration port geometry
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_REQ_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_REQ_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_TSIZE_OFFERED  = 2'd2;
    localparam logic [1:0] REG_OFFERED_TSIZE  = 2'd3;

    localparam logic [15:0] DEFAULT_BLOCK_SIZE = 16'd512;
    localparam logic [15:0] NO_ACK_YET         = 16'hFFFF;

    // Event types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ACK   = 2'd1;
    localparam logic [1:0] REQ_OACK  = 2'd2;
    localparam logic [1:0] REQ_DATA  = 2'd3;

    // Actions
    localparam logic [1:0] ACT_WAIT  = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_ERROR = 2'd2;
    localparam logic [1:0] ACT_DONE  = 2'd3;

    // Error packet kinds
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_REFUSED = 2'd2;

    // Final status
    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_XFER    = 2'd2;
    localparam logic [1:0] ST_OPT     = 2'd3;

    // Failing checks
    localparam logic [4:0] CAUSE_NONE        = 5'd0;
    localparam logic [4:0] CAUSE_DATA_RX     = 5'd1;
    localparam logic [4:0] CAUSE_ACK_WRONG   = 5'd2;
    localparam logic [4:0] CAUSE_ACK0_REFUSE = 5'd3;
    localparam logic [4:0] CAUSE_OACK_LATE   = 5'd4;
    localparam logic [4:0] CAUSE_OACK_EMPTY  = 5'd5;
    localparam logic [4:0] CAUSE_BS_UNREQ    = 5'd6;
    localparam logic [4:0] CAUSE_BS_BAD      = 5'd7;
    localparam logic [4:0] CAUSE_BS_ABOVE    = 5'd8;
    localparam logic [4:0] CAUSE_TO_UNREQ    = 5'd9;
    localparam logic [4:0] CAUSE_TO_BAD      = 5'd10;
    localparam logic [4:0] CAUSE_TO_DIFF     = 5'd11;
    localparam logic [4:0] CAUSE_TS_UNREQ    = 5'd12;
    localparam logic [4:0] CAUSE_TS_BAD      = 5'd13;
    localparam logic [4:0] CAUSE_TS_DIFF     = 5'd14;
    localparam logic [4:0] CAUSE_PEER_REFUSE = 5'd15;
    localparam logic [4:0] CAUSE_UNKNOWN     = 5'd16;

    typedef struct packed {
        logic [15:0] req_block_size;
        logic [7:0]  req_timeout;
        logic        tsize_offered;
        logic [31:0] offered_tsize;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] block_number;
        logic [15:0] chunk_len;
        logic [15:0] bs_value;
        logic [7:0]  to_value;
        logic        ts_present;
        logic [31:0] ts_value;
        logic [2:0]  decode_ok;
        logic        options_empty;
        logic        peer_accepts;
        logic        unknown_left;
    } t_event;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] data_block;
        logic [15:0] data_len;
        logic [1:0]  error_kind;
        logic [1:0]  final_status;
        logic [4:0]  fail_cause;
        logic [7:0]  new_timeout;
    } t_result;

    typedef struct packed {
        logic [15:0] sent_block;
        logic [15:0] acked_block;
        logic        final_sent;
        logic [15:0] block_size;
        logic        finished;
    } t_state;

    localparam t_state STATE_RESET = '{
        sent_block:  16'd0,
        acked_block: NO_ACK_YET,
        final_sent:  1'b0,
        block_size:  DEFAULT_BLOCK_SIZE,
        finished:    1'b0
    };

endpackage

`default_nettype wire

// ===== rtl/tws_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tws_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tws_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tws_pkg::DATA_W-1:0] pwdata,
    output logic      [tws_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output tws_pkg::t_cfg                   o_cfg
);

    tws_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                tws_pkg::REG_REQ_BLOCK_SIZE: r_cfg.req_block_size <= pwdata[15:0];
                tws_pkg::REG_REQ_TIMEOUT:    r_cfg.req_timeout    <= pwdata[7:0];
                tws_pkg::REG_TSIZE_OFFERED:  r_cfg.tsize_offered  <= pwdata[0];
                tws_pkg::REG_OFFERED_TSIZE:  r_cfg.offered_tsize  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            tws_pkg::REG_REQ_BLOCK_SIZE: prdata = {16'd0, r_cfg.req_block_size};
            tws_pkg::REG_REQ_TIMEOUT:    prdata = {24'd0, r_cfg.req_timeout};
            tws_pkg::REG_TSIZE_OFFERED:  prdata = {31'd0, r_cfg.tsize_offered};
            tws_pkg::REG_OFFERED_TSIZE:  prdata = r_cfg.offered_tsize;
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/tws_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tws_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire tws_pkg::t_cfg   i_cfg,
    input  wire tws_pkg::t_event i_event,
    output tws_pkg::t_result     o_result
);

    tws_pkg::t_state  r_st;
    tws_pkg::t_state  n_st;
    tws_pkg::t_result res;
    logic [15:0]      bs_eff;
    logic [15:0]      send_bsz;
    logic [15:0]      send_len;
    logic [15:0]      send_blk;
    logic             do_send;
    logic             do_fail;
    logic [1:0]       f_kind;
    logic [1:0]       f_status;
    logic [4:0]       f_cause;

    // Block size in force for this send: an accepted OACK value replaces it
    assign bs_eff   = (i_event.bs_value != 16'd0) ? i_event.bs_value : r_st.block_size;
    assign send_bsz = (i_event.req_type == tws_pkg::REQ_OACK) ? bs_eff : r_st.block_size;
    assign send_len = (i_event.chunk_len < send_bsz) ? i_event.chunk_len : send_bsz;
    assign send_blk = r_st.sent_block + 16'd1;

    // Decide one event against the current state
    always_comb begin
        n_st     = r_st;
        res      = '0;
        do_send  = 1'b0;
        do_fail  = 1'b0;
        f_kind   = tws_pkg::ERR_REFUSED;
        f_status = tws_pkg::ST_OPT;
        f_cause  = tws_pkg::CAUSE_NONE;

        if (i_event.req_type == tws_pkg::REQ_START) begin
            n_st = tws_pkg::STATE_RESET;
        end else if (r_st.finished) begin
            // drop everything until the next start
        end else if (i_event.req_type == tws_pkg::REQ_DATA) begin
            do_fail  = 1'b1;
            f_kind   = tws_pkg::ERR_ILLEGAL;
            f_status = tws_pkg::ST_XFER;
            f_cause  = tws_pkg::CAUSE_DATA_RX;
        end else if (i_event.req_type == tws_pkg::REQ_ACK) begin
            if (i_event.block_number == r_st.acked_block) begin
                // duplicate ACK: ignore
            end else if (i_event.block_number != r_st.sent_block) begin
                do_fail  = 1'b1;
                f_kind   = tws_pkg::ERR_ILLEGAL;
                f_status = tws_pkg::ST_XFER;
                f_cause  = tws_pkg::CAUSE_ACK_WRONG;
            end else begin
                n_st.acked_block = i_event.block_number;
                if (i_event.block_number == 16'd0 && !i_event.peer_accepts) begin
                    do_fail  = 1'b1;
                    f_kind   = tws_pkg::ERR_REFUSED;
                    f_status = tws_pkg::ST_XFER;
                    f_cause  = tws_pkg::CAUSE_ACK0_REFUSE;
                end else if (r_st.final_sent) begin
                    res.action       = tws_pkg::ACT_DONE;
                    res.final_status = tws_pkg::ST_OK;
                    n_st.finished    = 1'b1;
                end else begin
                    do_send = 1'b1;
                end
            end
        end else begin
            // OACK checks, first failing one wins
            if (r_st.acked_block != tws_pkg::NO_ACK_YET) begin
                do_fail  = 1'b1;
                f_kind   = tws_pkg::ERR_ILLEGAL;
                f_status = tws_pkg::ST_XFER;
                f_cause  = tws_pkg::CAUSE_OACK_LATE;
            end else if (i_event.options_empty) begin
                do_fail  = 1'b1;
                f_kind   = tws_pkg::ERR_ILLEGAL;
                f_status = tws_pkg::ST_XFER;
                f_cause  = tws_pkg::CAUSE_OACK_EMPTY;
            end else if (i_cfg.req_block_size == 16'd0 && i_event.bs_value != 16'd0) begin
                do_fail = 1'b1;
                f_cause = tws_pkg::CAUSE_BS_UNREQ;
            end else if (!i_event.decode_ok[0]) begin
                do_fail = 1'b1;
                f_cause = tws_pkg::CAUSE_BS_BAD;
            end else if (i_event.bs_value != 16'd0
                         && i_event.bs_value > i_cfg.req_block_size) begin
                do_fail = 1'b1;
                f_cause = tws_pkg::CAUSE_BS_ABOVE;
            end else begin
                n_st.block_size = bs_eff;
                if (i_cfg.req_timeout == 8'd0 && i_event.to_value != 8'd0) begin
                    do_fail = 1'b1;
                    f_cause = tws_pkg::CAUSE_TO_UNREQ;
                end else if (!i_event.decode_ok[1]) begin
                    do_fail = 1'b1;
                    f_cause = tws_pkg::CAUSE_TO_BAD;
                end else if (i_event.to_value != 8'd0
                             && i_event.to_value != i_cfg.req_timeout) begin
                    do_fail = 1'b1;
                    f_cause = tws_pkg::CAUSE_TO_DIFF;
                end else begin
                    // timeout is reported even if a later check fails
                    res.new_timeout = i_event.to_value;
                    if (!i_cfg.tsize_offered && i_event.ts_present) begin
                        do_fail = 1'b1;
                        f_cause = tws_pkg::CAUSE_TS_UNREQ;
                    end else if (!i_event.decode_ok[2]) begin
                        do_fail = 1'b1;
                        f_cause = tws_pkg::CAUSE_TS_BAD;
                    end else if (i_event.ts_present
                                 && i_event.ts_value != i_cfg.offered_tsize) begin
                        do_fail = 1'b1;
                        f_cause = tws_pkg::CAUSE_TS_DIFF;
                    end else if (!i_event.peer_accepts) begin
                        do_fail = 1'b1;
                        f_cause = tws_pkg::CAUSE_PEER_REFUSE;
                    end else if (i_event.unknown_left) begin
                        do_fail = 1'b1;
                        f_cause = tws_pkg::CAUSE_UNKNOWN;
                    end else begin
                        do_send = 1'b1;
                    end
                end
            end
        end

        // Send the next data block
        if (do_send) begin
            res.action      = tws_pkg::ACT_SEND;
            res.data_block  = send_blk;
            res.data_len    = send_len;
            n_st.sent_block = send_blk;
            if (send_len < send_bsz) begin
                n_st.final_sent = 1'b1;
            end
        end

        // Send an error and finish
        if (do_fail) begin
            res.action       = tws_pkg::ACT_ERROR;
            res.error_kind   = f_kind;
            res.final_status = f_status;
            res.fail_cause   = f_cause;
            n_st.finished    = 1'b1;
        end
    end

    // Advance state on each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tws_pkg::STATE_RESET;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_result = res;

    // A failing event leaves the transfer finished
    a_fail_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.action == tws_pkg::ACT_ERROR |=> r_st.finished)
        else $error("error result did not finish the transfer");

    // Once finished, only a start produces anything but an all-zero result
    a_finished_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.finished && i_event.req_type != tws_pkg::REQ_START |-> res == '0)
        else $error("result produced after finish");

    // A sent block advances the sent counter by one
    a_send_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.action == tws_pkg::ACT_SEND
        |=> r_st.sent_block == $past(r_st.sent_block) + 16'd1)
        else $error("sent block counter did not advance");

endmodule

`default_nettype wire

// ===== rtl/tftp_write_sender_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// TFTP write sender, one event per beat.
// Input channel (i_in_valid / o_in_ready) carries one event: start, ACK,
// OACK with decoded option fields, or DATA. Output channel (o_out_valid /
// i_out_ready) carries exactly one result beat per event: the action, the
// data block number and length to send, the error kind, the final status,
// the failing check and any timeout taken from the OACK.
// An accepted event is held in an input register; the decision logic reads
// it against the transfer state and the result is captured in the output
// register when that register is free, which presents it as a result beat.
// Sustained rate is one event per cycle while the receiver takes each beat,
// as the decision step between the two registers is combinational.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more event; further events wait on o_in_ready.
// Reset empties both registers, clears the option registers to 0 and puts
// the transfer state to: nothing sent, nothing acknowledged, block size 512.
// The user must write the APB option registers only while idle; not enforced.
module tftp_write_sender_step_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tws_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tws_pkg::DATA_W-1:0] pwdata,
    output logic      [tws_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    // event channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [15:0]                i_block_number,
    input  wire logic [15:0]                i_chunk_len,
    input  wire logic [15:0]                i_bs_value,
    input  wire logic [7:0]                 i_to_value,
    input  wire logic                       i_ts_present,
    input  wire logic [31:0]                i_ts_value,
    input  wire logic [2:0]                 i_decode_ok,
    input  wire logic                       i_options_empty,
    input  wire logic                       i_peer_accepts,
    input  wire logic                       i_unknown_left,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_action,
    output logic [15:0]                     o_data_block,
    output logic [15:0]                     o_data_len,
    output logic [1:0]                      o_error_kind,
    output logic [1:0]                      o_final_status,
    output logic [4:0]                      o_fail_cause,
    output logic [7:0]                      o_new_timeout
);

    tws_pkg::t_cfg    cfg;
    tws_pkg::t_event  in_beat;
    tws_pkg::t_event  r_in;
    tws_pkg::t_result result;
    tws_pkg::t_result r_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             step;

    assign in_beat = '{
        req_type:      i_req_type,
        block_number:  i_block_number,
        chunk_len:     i_chunk_len,
        bs_value:      i_bs_value,
        to_value:      i_to_value,
        ts_present:    i_ts_present,
        ts_value:      i_ts_value,
        decode_ok:     i_decode_ok,
        options_empty: i_options_empty,
        peer_accepts:  i_peer_accepts,
        unknown_left:  i_unknown_left
    };

    tws_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Output register is free when empty or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    tws_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_event  (r_in),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= in_beat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_out.action;
    assign o_data_block   = r_out.data_block;
    assign o_data_len     = r_out.data_len;
    assign o_error_kind   = r_out.error_kind;
    assign o_final_status = r_out.final_status;
    assign o_fail_cause   = r_out.fail_cause;
    assign o_new_timeout  = r_out.new_timeout;

    // Input side stalls only with both registers full and the output blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a full pipeline");

    // A processed event always lands as a result beat
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("processed event produced no result beat");

    // An error result always names its failing check
    a_error_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == tws_pkg::ACT_ERROR
        |-> o_fail_cause != tws_pkg::CAUSE_NONE && o_error_kind != tws_pkg::ERR_NONE)
        else $error("error result without cause");

endmodule

`default_nettype wire
